[sv/utf8dc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decode and charset classify: shared package
// Types, codes and small character-class functions used by the decoder and
// by the top level.
// ----------------------------------------------------------------------------
package utf8dc_pkg;

   localparam int unsigned CpWidth = 31;
   localparam int unsigned MaskWidth = 3;
   localparam logic [2:0] HALT_MARK = 3'd7;

   // Register indexes of the configuration port.
   localparam logic [0:0] REG_TARGET_MASK = 1'b0;
   localparam logic [MaskWidth-1:0] TARGET_MASK_RESET = 3'd2;

   typedef enum logic [1:0] {
      CLASS_ASCII   = 2'd0,
      CLASS_UTF8    = 2'd1,
      CLASS_LATIN1  = 2'd2,
      CLASS_UNKNOWN = 2'd3
   } charset_class_type;

   typedef enum logic [2:0] {
      ACT_NONE         = 3'd0,
      ACT_LATIN1_UTF8  = 3'd1,
      ACT_LATIN1_ASCII = 3'd2,
      ACT_UTF8_LATIN1  = 3'd3,
      ACT_UTF8_ASCII   = 3'd4,
      ACT_IMPOSSIBLE   = 3'd5
   } transcode_action_type;

   typedef struct packed {
      logic                 cp_valid;
      logic [CpWidth-1:0]   code_point;
      logic                 cp_good;
      logic                 decode_error;
      logic                 string_done;
      charset_class_type    charset_class;
      transcode_action_type transcode_action;
   } result_type;

   // Tab, line feed, carriage return and printable ASCII.
   function automatic logic printable_char(input logic [7:0] c);
      return ((c >= 8'd32) && (c < 8'd127)) || (c == 8'd9) || (c == 8'd10) ||
             (c == 8'd13);
   endfunction

   // Acceptable code point: good ASCII, or U+00A0 and above except the
   // surrogate block, the byte order mark U+FEFF and the noncharacters U+FFFE and U+FFFF.
   function automatic logic acceptable_char(input logic [CpWidth-1:0] c);
      logic low_ascii;
      logic high_ok;
      low_ascii = (c[CpWidth-1:8] == '0) && printable_char(c[7:0]);
      high_ok = (c >= 31'd160) && (c[CpWidth-1:11] != 20'h0001b) &&
                (c != 31'h0000feff) && (c != 31'h0000fffe) &&
                (c != 31'h0000ffff);
      return low_ascii || high_ok;
   endfunction

   // Sequence length announced by a lead byte; zero for a bad lead byte.
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] n;
      priority if (b < 8'hc2) n = 3'd0;
      else if (b < 8'he0) n = 3'd2;
      else if (b < 8'hf0) n = 3'd3;
      else if (b < 8'hf8) n = 3'd4;
      else if (b < 8'hfc) n = 3'd5;
      else if (b < 8'hfe) n = 3'd6;
      else n = 3'd0;
      return n;
   endfunction

   // Payload bits of a lead byte for a sequence of length n.
   function automatic logic [CpWidth-1:0] lead_bits(input logic [7:0] b,
                                                    input logic [2:0] n);
      logic [CpWidth-1:0] v;
      unique case (n)
         3'd2:    v = {26'd0, b[4:0]};
         3'd3:    v = {27'd0, b[3:0]};
         3'd4:    v = {28'd0, b[2:0]};
         3'd5:    v = {29'd0, b[1:0]};
         3'd6:    v = {30'd0, b[0]};
         default: v = '0;
      endcase
      return v;
   endfunction

   // A sequence of three or more bytes is overlong when its value lies below
   // the smallest value that needs that many bytes.
   function automatic logic overlong(input logic [CpWidth-1:0] v,
                                     input logic [2:0] n);
      logic r;
      unique case (n)
         3'd3:    r = (v[CpWidth-1:11] == '0);
         3'd4:    r = (v[CpWidth-1:16] == '0);
         3'd5:    r = (v[CpWidth-1:21] == '0);
         3'd6:    r = (v[CpWidth-1:26] == '0);
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Transcoding needed to reach a charset the mask accepts. Accepting UTF-8
   // or Latin-1 also accepts plain ASCII.
   function automatic transcode_action_type action_for(
         input charset_class_type cls, input logic [MaskWidth-1:0] mask);
      logic [MaskWidth-1:0] m;
      transcode_action_type act;
      m = mask;
      m[0] = mask[0] | mask[1] | mask[2];
      unique case (cls)
         CLASS_ASCII:  act = m[0] ? ACT_NONE : ACT_IMPOSSIBLE;
         CLASS_UTF8:   act = m[1] ? ACT_NONE :
                             (m[2] ? ACT_UTF8_LATIN1 : ACT_UTF8_ASCII);
         CLASS_LATIN1: act = m[2] ? ACT_NONE :
                             (m[1] ? ACT_LATIN1_UTF8 : ACT_LATIN1_ASCII);
         default:      act = ACT_IMPOSSIBLE;
      endcase
      return act;
   endfunction

endpackage
`default_nettype wire

[sv/utf8_decode_charset_classify_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decode and charset classify unit
// Decodes a zero-terminated byte string as extended UTF-8, reports each code
// point and, at the terminator, the string's charset class and transcoding.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the req_ channel (valid/ready); one result transaction
// leaves on the rsp_ channel for every byte transaction, in order. A zero
// byte ends the string: its result carries the class and the transcoding
// action, and the decoder state returns to its start values.
// The target charset mask is written through the csr_ APB-style port; the user
// must write it only while no transaction is in flight. The block does not enforce it.
// An accepted byte is held in the input register, then decoded and loaded into
// the result register once that register is free to load.
// Throughput: one byte per cycle. The input register and the result register
// each hold one transaction, and the decode between them is a single pass.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more byte; only then does req_ready fall.
// Reset (synchronous, active high) empties both registers, clears the decode
// state and sets the target mask to accept UTF-8 (and hence ASCII).
// ----------------------------------------------------------------------------
module utf8_decode_charset_classify_unit
   import utf8dc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // Byte input channel.
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_text_byte,
   // Result channel.
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_cp_valid,
   output logic [30:0]       rsp_code_point,
   output logic              rsp_cp_good,
   output logic              rsp_decode_error,
   output logic              rsp_string_done,
   output logic [1:0]        rsp_charset_class,
   output logic [2:0]        rsp_transcode_action,
   // Configuration port.
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic      [31:0]  csr_prdata,
   output logic              csr_pready
);

   logic [MaskWidth-1:0] target_mask;

   // Input register stage.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Result register stage.
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       out_free;
   logic       advance;
   logic       req_take;
   result_type step_result;

   utf8dc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .target_mask (target_mask)
   );

   // The result register can load when it is empty or its transaction leaves
   // in this cycle; the input byte moves through the decoder at that moment.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   utf8dc_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .text_byte   (in_byte_ff),
      .target_mask (target_mask),
      .result      (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = step_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_cp_valid         = out_ff.cp_valid;
   assign rsp_code_point       = out_ff.code_point;
   assign rsp_cp_good          = out_ff.cp_good;
   assign rsp_decode_error     = out_ff.decode_error;
   assign rsp_string_done      = out_ff.string_done;
   assign rsp_charset_class    = out_ff.charset_class;
   assign rsp_transcode_action = out_ff.transcode_action;

   // A decoded code point and a decode error never come from the same byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_cp_valid && rsp_decode_error))
      else $error("code point and decode error reported together");

   // Class and action are only given at the terminator.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_string_done) |->
         (rsp_charset_class == CLASS_ASCII && rsp_transcode_action == ACT_NONE))
      else $error("class or action outside the terminator");

   // A terminator never carries a code point.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_done) |-> !rsp_cp_valid && !rsp_cp_good)
      else $error("code point on the terminator");

   // The decoder only steps when the input stage holds a byte and the result
   // stage can take it; a stalled result must therefore stay put.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_ff)))
      else $error("stalled result overwritten");

   // An acceptable-character flag needs a decoded code point.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cp_good) |-> rsp_cp_valid)
      else $error("good flag without a code point");

endmodule
`default_nettype wire

[sv/utf8dc_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decode and charset classify: configuration registers
// APB-style access to the target charset mask.
// ----------------------------------------------------------------------------
module utf8dc_csr
   import utf8dc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic      [31:0]          csr_prdata,
   output logic                      csr_pready,
   output logic      [MaskWidth-1:0] target_mask
);

   logic [MaskWidth-1:0] target_mask_ff;
   logic [MaskWidth-1:0] target_mask_in;
   logic                 hit_mask;

   // Registers sit on 4-byte boundaries; the low address bits are ignored.
   assign hit_mask = (csr_paddr[2] == REG_TARGET_MASK);

   always_comb begin
      target_mask_in = target_mask_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit_mask) begin
         target_mask_in = csr_pwdata[MaskWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_mask_ff <= TARGET_MASK_RESET;
      end else begin
         target_mask_ff <= target_mask_in;
      end
   end

   assign csr_pready  = 1'b1;
   assign csr_prdata  = hit_mask ? {{(32 - MaskWidth){1'b0}}, target_mask_ff} : 32'd0;
   assign target_mask = target_mask_ff;

endmodule
`default_nettype wire

[sv/utf8dc_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decode and charset classify: decode step
// Holds the sequence state and sticky charset flags and works out the result
// of one byte. The state moves only when the byte is taken (advance high).
// ----------------------------------------------------------------------------
module utf8dc_decode
   import utf8dc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [7:0]           text_byte,
   input  wire logic [MaskWidth-1:0] target_mask,
   output result_type                result
);

   logic [2:0]         bytes_left_ff, bytes_left_in;
   logic [2:0]         seq_length_ff, seq_length_in;
   logic [CpWidth-1:0] acc_ff, acc_in;
   logic               utf8_ok_ff, utf8_ok_in;
   logic               ascii_ok_ff, ascii_ok_in;
   logic               latin1_ok_ff, latin1_ok_in;

   logic               halted;
   logic               halt_now;
   logic               cut_short;
   logic [2:0]         lead_n;
   logic [CpWidth-1:0] acc_next;
   charset_class_type  cls;

   assign halted    = (seq_length_ff == HALT_MARK);
   assign cut_short = !halted && (bytes_left_ff != 3'd0);
   assign lead_n    = lead_len(text_byte);
   assign acc_next  = {acc_ff[CpWidth-7:0], text_byte[5:0]};

   always_comb begin
      bytes_left_in = bytes_left_ff;
      seq_length_in = seq_length_ff;
      acc_in        = acc_ff;
      utf8_ok_in    = utf8_ok_ff;
      ascii_ok_in   = ascii_ok_ff;
      latin1_ok_in  = latin1_ok_ff;
      halt_now      = 1'b0;
      result        = '0;

      // A sequence cut short by the terminator already rules out UTF-8.
      if (ascii_ok_ff) begin
         cls = CLASS_ASCII;
      end else if (utf8_ok_ff && !cut_short) begin
         cls = CLASS_UTF8;
      end else if (latin1_ok_ff) begin
         cls = CLASS_LATIN1;
      end else begin
         cls = CLASS_UNKNOWN;
      end

      if (text_byte == 8'd0) begin
         // Terminator: a sequence cut short is an error, then everything resets.
         result.decode_error     = cut_short;
         result.string_done      = 1'b1;
         result.charset_class    = cls;
         result.transcode_action = action_for(cls, target_mask);
         bytes_left_in = '0;
         seq_length_in = '0;
         acc_in        = '0;
         utf8_ok_in    = 1'b1;
         ascii_ok_in   = 1'b1;
         latin1_ok_in  = 1'b1;
      end else begin
         ascii_ok_in  = ascii_ok_ff && printable_char(text_byte);
         latin1_ok_in = latin1_ok_ff && (printable_char(text_byte) || text_byte >= 8'd160);

         if (halted) begin
            // Decoding stopped after an earlier error.
         end else if (bytes_left_ff == 3'd0) begin
            if (!text_byte[7]) begin
               result.cp_valid   = 1'b1;
               result.code_point = {{(CpWidth - 8){1'b0}}, text_byte};
            end else if (lead_n == 3'd0) begin
               halt_now = 1'b1;
            end else begin
               seq_length_in = lead_n;
               bytes_left_in = lead_n - 3'd1;
               acc_in        = lead_bits(text_byte, lead_n);
            end
         end else begin
            if (text_byte[7:6] != 2'b10) begin
               halt_now = 1'b1;
            end else begin
               bytes_left_in = bytes_left_ff - 3'd1;
               acc_in        = acc_next;
               if (bytes_left_ff == 3'd1) begin
                  if (overlong(acc_next, seq_length_ff)) begin
                     halt_now = 1'b1;
                  end else begin
                     result.cp_valid   = 1'b1;
                     result.code_point = acc_next;
                     seq_length_in     = '0;
                     acc_in            = '0;
                  end
               end
            end
         end

         if (result.cp_valid) begin
            result.cp_good = acceptable_char(result.code_point);
            if (!result.cp_good) begin
               utf8_ok_in = 1'b0;
            end
         end

         if (halt_now) begin
            result.decode_error = 1'b1;
            seq_length_in = HALT_MARK;
            bytes_left_in = '0;
            acc_in        = '0;
            utf8_ok_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         seq_length_ff <= '0;
         acc_ff        <= '0;
         utf8_ok_ff    <= 1'b1;
         ascii_ok_ff   <= 1'b1;
         latin1_ok_ff  <= 1'b1;
      end else if (advance) begin
         bytes_left_ff <= bytes_left_in;
         seq_length_ff <= seq_length_in;
         acc_ff        <= acc_in;
         utf8_ok_ff    <= utf8_ok_in;
         ascii_ok_ff   <= ascii_ok_in;
         latin1_ok_ff  <= latin1_ok_in;
      end
   end

endmodule
`default_nettype wire
